// File: rtl/core/nca_pkg.sv
// Shared types, constants and defaults for the nearest-centroid assignment unit.
`default_nettype none

package nca_pkg;

   localparam int DEFAULT_MAX_CLUSTERS = 16;
   localparam int DEFAULT_MAX_DIMS     = 4;

   localparam int COORD_WIDTH     = 16;
   localparam int IN_COORDS       = 4;
   localparam int ENTRY_WIDTH     = 4;
   localparam int DIST_WIDTH      = 34;
   localparam int CLUSTERS_WIDTH  = 5;
   localparam int DIMS_WIDTH      = 3;
   localparam int CSR_DATA_WIDTH  = 5;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACTIVE_CLUSTERS = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACTIVE_DIMS     = 1'b1;

   localparam logic [CLUSTERS_WIDTH-1:0] ACTIVE_CLUSTERS_RESET = 5'd1;
   localparam logic [DIMS_WIDTH-1:0]     ACTIVE_DIMS_RESET     = 3'd4;

   localparam logic OP_LOAD     = 1'b0;
   localparam logic OP_CLASSIFY = 1'b1;

   typedef struct packed {
      logic                          op;
      logic [ENTRY_WIDTH-1:0]        entry_index;
      logic signed [COORD_WIDTH-1:0] coord_zero;
      logic signed [COORD_WIDTH-1:0] coord_one;
      logic signed [COORD_WIDTH-1:0] coord_two;
      logic signed [COORD_WIDTH-1:0] coord_three;
   } req_type;

   typedef struct packed {
      logic [ENTRY_WIDTH-1:0] nearest_index;
      logic [DIST_WIDTH-1:0]  min_distance;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic start;
      logic issue;
      logic last;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// File: rtl/core/nca_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module nca_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     write_en,
   input  wire logic [$clog2(DEPTH)-1:0] write_addr,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic                     read_en,
   input  wire logic [$clog2(DEPTH)-1:0] read_addr,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_en) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/nca_datapath.sv
// Datapath: centroid store, distance pipeline, running minimum and result register.
`default_nettype none

module nca_datapath #(
   parameter int MAX_CLUSTERS = nca_pkg::DEFAULT_MAX_CLUSTERS,
   parameter int MAX_DIMS     = nca_pkg::DEFAULT_MAX_DIMS
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_write_en,
   input  wire logic [nca_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [nca_pkg::CSR_DATA_WIDTH-1:0]     csr_data,
   input  wire nca_pkg::req_type                       req_payload,
   input  wire nca_pkg::cmd_type                       cmd,
   input  wire logic [$clog2(MAX_CLUSTERS)-1:0]        rd_addr,
   output nca_pkg::status_type                         status,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output nca_pkg::rsp_type                            rsp_payload
);

   localparam int IDX_W  = $clog2(MAX_CLUSTERS);
   localparam int CW     = nca_pkg::COORD_WIDTH;
   localparam int RAM_W  = MAX_DIMS * CW;
   localparam int SQ_W   = 2 * CW + 1;
   localparam int SUM_W  = nca_pkg::DIST_WIDTH + $clog2(MAX_DIMS);
   localparam int EXT_W  = IDX_W + nca_pkg::ENTRY_WIDTH;

   logic signed [CW-1:0]   req_coord  [nca_pkg::IN_COORDS];
   logic signed [CW-1:0]   load_lane  [MAX_DIMS];
   logic signed [CW-1:0]   cent_lane  [MAX_DIMS];
   logic signed [CW-1:0]   point_ff   [MAX_DIMS];
   logic signed [CW-1:0]   point_in   [MAX_DIMS];
   logic signed [CW:0]     diff       [MAX_DIMS];
   logic signed [2*CW+1:0] prod       [MAX_DIMS];
   logic [SQ_W-1:0]        sq_in      [MAX_DIMS];
   logic [SQ_W-1:0]        sq_ff      [MAX_DIMS];
   logic [RAM_W-1:0]       ram_wdata;
   logic [RAM_W-1:0]       ram_rdata;
   logic [EXT_W-1:0]       entry_ext;
   logic                   load_en;

   logic [nca_pkg::DIMS_WIDTH-1:0] active_dims_ff;
   logic [nca_pkg::DIMS_WIDTH-1:0] active_dims_in;

   logic             s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic             s1_last_ff, s2_last_ff, s3_last_ff;
   logic [IDX_W-1:0] s1_idx_ff, s2_idx_ff, s3_idx_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0] sum_in;
   logic [SUM_W-1:0] best_dist_ff;
   logic [SUM_W-1:0] best_dist_in;
   logic [IDX_W-1:0] best_idx_ff;
   logic [IDX_W-1:0] best_idx_in;
   logic             scan_done_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [EXT_W-1:0] best_idx_ext;
   nca_pkg::rsp_type rsp_payload_ff;
   nca_pkg::rsp_type rsp_payload_in;

   assign req_coord[0] = req_payload.coord_zero;
   assign req_coord[1] = req_payload.coord_one;
   assign req_coord[2] = req_payload.coord_two;
   assign req_coord[3] = req_payload.coord_three;

   for (genvar j = 0; j < MAX_DIMS; j++) begin : g_lane
      if (j < nca_pkg::IN_COORDS) begin : g_in
         assign load_lane[j] = req_coord[j];
      end else begin : g_zero
         assign load_lane[j] = '0;
      end
      assign ram_wdata[j*CW +: CW] = load_lane[j];
      assign cent_lane[j]          = ram_rdata[j*CW +: CW];
      assign point_in[j]           = cmd.start ? load_lane[j] : point_ff[j];
   end

   assign entry_ext = EXT_W'(req_payload.entry_index);
   assign load_en   = cmd.load && (entry_ext < EXT_W'(MAX_CLUSTERS));

   nca_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_CLUSTERS)
   ) u_centroid_ram (
      .clock      (clock),
      .write_en   (load_en),
      .write_addr (entry_ext[IDX_W-1:0]),
      .write_data (ram_wdata),
      .read_en    (cmd.issue),
      .read_addr  (rd_addr),
      .read_data  (ram_rdata)
   );

   always_comb begin
      active_dims_in = active_dims_ff;
      if (csr_write_en && (csr_index == nca_pkg::CSR_ACTIVE_DIMS)) begin
         active_dims_in = csr_data[nca_pkg::DIMS_WIDTH-1:0];
      end
   end

   always_comb begin
      for (int j = 0; j < MAX_DIMS; j++) begin
         diff[j]  = {point_ff[j][CW-1], point_ff[j]} - {cent_lane[j][CW-1], cent_lane[j]};
         prod[j]  = diff[j] * diff[j];
         sq_in[j] = (int'(active_dims_ff) > j) ? prod[j][SQ_W-1:0] : '0;
      end
   end

   always_comb begin
      sum_in = '0;
      for (int j = 0; j < MAX_DIMS; j++) begin
         sum_in = sum_in + SUM_W'(sq_ff[j]);
      end
   end

   always_comb begin
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      if (s3_valid_ff && ((s3_idx_ff == '0) || (sum_ff < best_dist_ff))) begin
         best_dist_in = sum_ff;
         best_idx_in  = s3_idx_ff;
      end
   end

   assign best_idx_ext = EXT_W'(best_idx_ff);

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      if (cmd.publish) begin
         rsp_valid_in                 = 1'b1;
         rsp_payload_in.nearest_index = best_idx_ext[nca_pkg::ENTRY_WIDTH-1:0];
         rsp_payload_in.min_distance  = best_dist_ff[nca_pkg::DIST_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_dims_ff <= nca_pkg::ACTIVE_DIMS_RESET;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
         scan_done_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         active_dims_ff <= active_dims_in;
         s1_valid_ff    <= cmd.issue;
         s2_valid_ff    <= s1_valid_ff;
         s3_valid_ff    <= s2_valid_ff;
         scan_done_ff   <= s3_valid_ff && s3_last_ff;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      point_ff       <= point_in;
      sq_ff          <= sq_in;
      s1_last_ff     <= cmd.last;
      s2_last_ff     <= s1_last_ff;
      s3_last_ff     <= s2_last_ff;
      s1_idx_ff      <= rd_addr;
      s2_idx_ff      <= s1_idx_ff;
      s3_idx_ff      <= s2_idx_ff;
      sum_ff         <= sum_in;
      best_dist_ff   <= best_dist_in;
      best_idx_ff    <= best_idx_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign status.scan_done = scan_done_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload      = rsp_payload_ff;

endmodule

`default_nettype wire

// File: rtl/core/nca_controller.sv
// Controller: request handshake, centroid scan sequencing and result hand-off.
`default_nettype none

module nca_controller #(
   parameter int MAX_CLUSTERS = nca_pkg::DEFAULT_MAX_CLUSTERS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_en,
   input  wire logic [nca_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [nca_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   input  wire logic                                req_valid,
   input  wire logic                                req_op,
   output logic                                     req_ready,
   input  wire nca_pkg::status_type                 status,
   output nca_pkg::cmd_type                         cmd,
   output logic [$clog2(MAX_CLUSTERS)-1:0]          rd_addr
);

   localparam int IDX_W = $clog2(MAX_CLUSTERS);
   localparam int LIM_W = ($clog2(MAX_CLUSTERS + 1) > nca_pkg::CLUSTERS_WIDTH) ?
                          $clog2(MAX_CLUSTERS + 1) : nca_pkg::CLUSTERS_WIDTH;

   nca_pkg::state_type state_ff;
   nca_pkg::state_type state_in;

   logic [nca_pkg::CLUSTERS_WIDTH-1:0] active_clusters_ff;
   logic [nca_pkg::CLUSTERS_WIDTH-1:0] active_clusters_in;
   logic [IDX_W-1:0]                   count_ff;
   logic [IDX_W-1:0]                   count_in;
   logic [LIM_W-1:0]                   clusters_ext;
   logic [LIM_W-1:0]                   limit;
   logic [LIM_W-1:0]                   limit_less;
   logic [IDX_W-1:0]                   last_idx;
   logic                               at_last;

   always_comb begin
      active_clusters_in = active_clusters_ff;
      if (csr_write_en && (csr_index == nca_pkg::CSR_ACTIVE_CLUSTERS)) begin
         active_clusters_in = csr_data[nca_pkg::CLUSTERS_WIDTH-1:0];
      end
   end

   always_comb begin
      clusters_ext = LIM_W'(active_clusters_ff);
      priority if (clusters_ext == '0) begin
         limit = LIM_W'(1);
      end else if (clusters_ext > LIM_W'(MAX_CLUSTERS)) begin
         limit = LIM_W'(MAX_CLUSTERS);
      end else begin
         limit = clusters_ext;
      end
      limit_less = limit - LIM_W'(1);
      last_idx   = limit_less[IDX_W-1:0];
   end

   assign at_last = (count_ff == last_idx);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      unique case (state_ff)
         nca_pkg::ST_IDLE: begin
            if (req_valid && (req_op == nca_pkg::OP_CLASSIFY)) begin
               state_in = nca_pkg::ST_SCAN;
               count_in = '0;
            end
         end
         nca_pkg::ST_SCAN: begin
            if (at_last) begin
               state_in = nca_pkg::ST_DRAIN;
            end else begin
               count_in = count_ff + IDX_W'(1);
            end
         end
         nca_pkg::ST_DRAIN: begin
            if (status.scan_done) begin
               state_in = nca_pkg::ST_DONE;
            end
         end
         nca_pkg::ST_DONE: begin
            if (status.out_free) begin
               state_in = nca_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nca_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         nca_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid && (req_op == nca_pkg::OP_LOAD);
            cmd.start = req_valid && (req_op == nca_pkg::OP_CLASSIFY);
         end
         nca_pkg::ST_SCAN: begin
            cmd.issue = 1'b1;
            cmd.last  = at_last;
         end
         nca_pkg::ST_DRAIN: begin
         end
         nca_pkg::ST_DONE: begin
            cmd.publish = status.out_free;
         end
         default: begin
         end
      endcase
   end

   assign rd_addr = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= nca_pkg::ST_IDLE;
         active_clusters_ff <= nca_pkg::ACTIVE_CLUSTERS_RESET;
         count_ff           <= '0;
      end else begin
         state_ff           <= state_in;
         active_clusters_ff <= active_clusters_in;
         count_ff           <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/nearest_centroid_assign_unit.sv
// Top level of the nearest-centroid assignment unit.
`default_nettype none

// A load beat writes one whole centroid into the table and gives no result. A
// classify beat compares the point with active_clusters centroids (at least
// one, at most MAX_CLUSTERS), one centroid per cycle with all coordinates in
// parallel, reading the centroid RAM once per cycle; the next beat can be
// taken in the same cycle as the result appears. The result waits in an
// output register, so loads are taken while it is pending. Configuration
// writes are taken at any time but belong to idle periods.

module nearest_centroid_assign_unit #(
   parameter int MAX_CLUSTERS = nca_pkg::DEFAULT_MAX_CLUSTERS,
   parameter int MAX_DIMS     = nca_pkg::DEFAULT_MAX_DIMS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_en,
   input  wire logic [nca_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [nca_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire nca_pkg::req_type                    req_payload,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output nca_pkg::rsp_type                         rsp_payload
);

   nca_pkg::cmd_type                  cmd;
   nca_pkg::status_type               status;
   logic [$clog2(MAX_CLUSTERS)-1:0]   rd_addr;

   nca_controller #(
      .MAX_CLUSTERS (MAX_CLUSTERS)
   ) u_controller (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_valid    (req_valid),
      .req_op       (req_payload.op),
      .req_ready    (req_ready),
      .status       (status),
      .cmd          (cmd),
      .rd_addr      (rd_addr)
   );

   nca_datapath #(
      .MAX_CLUSTERS (MAX_CLUSTERS),
      .MAX_DIMS     (MAX_DIMS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_payload  (req_payload),
      .cmd          (cmd),
      .rd_addr      (rd_addr),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload)
   );

endmodule

`default_nettype wire

// File: tb/sv/nearest_centroid_assign_unit_test.sv
// Self-checking testbench for the nearest-centroid assignment unit.
`timescale 1ns / 100ps

module nearest_centroid_assign_unit_test;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 10;
   localparam int DRAIN_CYCLES  = 24;
   localparam int PHASE_ITEMS   = 100;
   localparam int PHASE_COUNT   = 8;
   localparam int REPORT_LIMIT  = 10;
   localparam int CLUSTER_SLOTS = nca_pkg::DEFAULT_MAX_CLUSTERS;
   localparam int DIM_SLOTS     = nca_pkg::DEFAULT_MAX_DIMS;
   localparam int COORD_MIN     = -32768;
   localparam int COORD_MAX     = 32767;
   localparam logic [nca_pkg::DIST_WIDTH-1:0] CORNER_DISTANCE = 34'd17179344900;

   typedef enum logic { ROW_CSR, ROW_BEAT } row_kind_type;

   typedef struct {
      row_kind_type                          kind;
      logic [nca_pkg::CSR_INDEX_WIDTH-1:0]   reg_index;
      logic [nca_pkg::CSR_DATA_WIDTH-1:0]    reg_value;
      nca_pkg::req_type                      beat;
      bit                                    typed;
      nca_pkg::rsp_type                      answer;
   } stim_row_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                csr_write_en = 1'b0;
   logic [nca_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [nca_pkg::CSR_DATA_WIDTH-1:0]  csr_data = '0;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   nca_pkg::req_type                    req_payload = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   nca_pkg::rsp_type                    rsp_payload;

   logic signed [nca_pkg::COORD_WIDTH-1:0] centroid_mirror [CLUSTER_SLOTS][DIM_SLOTS];
   logic [nca_pkg::CLUSTERS_WIDTH-1:0] clusters_setting = nca_pkg::ACTIVE_CLUSTERS_RESET;
   logic [nca_pkg::DIMS_WIDTH-1:0]     dims_setting = nca_pkg::ACTIVE_DIMS_RESET;
   nca_pkg::rsp_type                   pending_nearest [$];
   stim_row_type                       directed_rows [$];
   int                                 sender_idle_pct = 0;
   int                                 receiver_stall_pct = 0;
   int                                 error_count = 0;

   nearest_centroid_assign_unit dut (
      .clock       (clock),
      .reset       (reset),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   initial begin
      #12_000_000;
      $display("nearest_centroid_assign_unit_test: done, errors");
      $finish;
   end

   function automatic nca_pkg::rsp_type nearest_centroid_of(nca_pkg::req_type point_beat);
      logic signed [nca_pkg::COORD_WIDTH-1:0] point [DIM_SLOTS];
      logic [63:0]      sum;
      logic [63:0]      best_sum;
      longint           diff;
      int               clusters;
      int               dims;
      int               best;
      int               l;
      int               j;
      nca_pkg::rsp_type result;
      point[0] = point_beat.coord_zero;
      point[1] = point_beat.coord_one;
      point[2] = point_beat.coord_two;
      point[3] = point_beat.coord_three;
      clusters = (clusters_setting == 0) ? 1 :
                 (clusters_setting > CLUSTER_SLOTS) ? CLUSTER_SLOTS : int'(clusters_setting);
      dims = (dims_setting > DIM_SLOTS) ? DIM_SLOTS : int'(dims_setting);
      best = 0;
      best_sum = '0;
      for (l = 0; l < clusters; l++) begin
         sum = '0;
         for (j = 0; j < dims; j++) begin
            diff = longint'(point[j]) - longint'(centroid_mirror[l][j]);
            sum += 64'(diff * diff);
         end
         if (l == 0 || sum < best_sum) begin
            best_sum = sum;
            best = l;
         end
      end
      result.nearest_index = best[nca_pkg::ENTRY_WIDTH-1:0];
      result.min_distance = best_sum[nca_pkg::DIST_WIDTH-1:0];
      return result;
   endfunction

   function automatic logic signed [nca_pkg::COORD_WIDTH-1:0] pick_coord();
      case ($urandom_range(7))
         0: return nca_pkg::COORD_WIDTH'(COORD_MIN);
         1: return nca_pkg::COORD_WIDTH'(COORD_MAX);
         2: return '0;
         default: return nca_pkg::COORD_WIDTH'($urandom);
      endcase
   endfunction

   function automatic logic signed [nca_pkg::COORD_WIDTH-1:0] near_coord(
      logic signed [nca_pkg::COORD_WIDTH-1:0] centre);
      return centre + nca_pkg::COORD_WIDTH'($urandom_range(127))
             - nca_pkg::COORD_WIDTH'(64);
   endfunction

   function automatic stim_row_type csr_row(logic [nca_pkg::CSR_INDEX_WIDTH-1:0] index,
                                            int value);
      stim_row_type row;
      row = '{kind: ROW_CSR, reg_index: index,
              reg_value: nca_pkg::CSR_DATA_WIDTH'(value),
              beat: '0, typed: 1'b0, answer: '0};
      return row;
   endfunction

   function automatic stim_row_type beat_row(logic op, int entry, int c0, int c1, int c2,
                                             int c3, bit typed, int index,
                                             logic [33:0] distance);
      stim_row_type row;
      row.kind = ROW_BEAT;
      row.reg_index = '0;
      row.reg_value = '0;
      row.beat.op = op;
      row.beat.entry_index = nca_pkg::ENTRY_WIDTH'(entry);
      row.beat.coord_zero = nca_pkg::COORD_WIDTH'(c0);
      row.beat.coord_one = nca_pkg::COORD_WIDTH'(c1);
      row.beat.coord_two = nca_pkg::COORD_WIDTH'(c2);
      row.beat.coord_three = nca_pkg::COORD_WIDTH'(c3);
      row.typed = typed;
      row.answer.nearest_index = nca_pkg::ENTRY_WIDTH'(index);
      row.answer.min_distance = distance;
      return row;
   endfunction

   // Entered and left at a falling edge; valid stays high into the next beat.
   task automatic send_beat(nca_pkg::req_type beat, bit typed, nca_pkg::rsp_type answer);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (beat.op == nca_pkg::OP_LOAD) begin
         centroid_mirror[beat.entry_index][0] = beat.coord_zero;
         centroid_mirror[beat.entry_index][1] = beat.coord_one;
         centroid_mirror[beat.entry_index][2] = beat.coord_two;
         centroid_mirror[beat.entry_index][3] = beat.coord_three;
      end else begin
         pending_nearest.push_back(typed ? answer : nearest_centroid_of(beat));
      end
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_nearest.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic [nca_pkg::CSR_INDEX_WIDTH-1:0] index,
                            logic [nca_pkg::CSR_DATA_WIDTH-1:0] value);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      if (index == nca_pkg::CSR_ACTIVE_CLUSTERS) begin
         clusters_setting = value;
      end else begin
         dims_setting = value[nca_pkg::DIMS_WIDTH-1:0];
      end
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      nca_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_nearest.size() == 0) begin
            if (error_count < REPORT_LIMIT) begin
               $display("unexpected beat: index %0d distance %0d",
                        rsp_payload.nearest_index, rsp_payload.min_distance);
            end
            error_count++;
         end else begin
            want = pending_nearest.pop_front();
            if (rsp_payload.nearest_index !== want.nearest_index ||
                rsp_payload.min_distance !== want.min_distance) begin
               if (error_count < REPORT_LIMIT) begin
                  $display("mismatch: index %0d/%0d distance %0d/%0d (expected/actual)",
                           want.nearest_index, rsp_payload.nearest_index,
                           want.min_distance, rsp_payload.min_distance);
               end
               error_count++;
            end
         end
      end
   end

   initial begin
      int               k;
      int               v;
      int               p;
      int               pick;
      int               phase_clusters [PHASE_COUNT] = '{16, 1, 31, 0, 3, 8, 16, 5};
      int               phase_dims [PHASE_COUNT] = '{4, 4, 7, 2, 0, 1, 3, 4};
      nca_pkg::req_type beat;

      // Pairs of entries share coordinates so that ties occur.
      directed_rows.push_back(beat_row(nca_pkg::OP_LOAD, 0, COORD_MIN, COORD_MIN, COORD_MIN,
                                       COORD_MIN, 1'b0, 0, '0));
      directed_rows.push_back(beat_row(nca_pkg::OP_CLASSIFY, 15, COORD_MAX, COORD_MAX,
                                       COORD_MAX, COORD_MAX, 1'b1, 0, CORNER_DISTANCE));
      directed_rows.push_back(beat_row(nca_pkg::OP_CLASSIFY, 0, COORD_MIN, COORD_MIN,
                                       COORD_MIN, COORD_MIN, 1'b1, 0, '0));
      for (k = 1; k < CLUSTER_SLOTS - 1; k++) begin
         v = k >> 1;
         directed_rows.push_back(beat_row(nca_pkg::OP_LOAD, k, v * 4000 - 16000,
                                          12000 - v * 3000, v * 111, -v * 77,
                                          1'b0, 0, '0));
      end
      directed_rows.push_back(beat_row(nca_pkg::OP_LOAD, 15, COORD_MAX, COORD_MAX,
                                       COORD_MAX, COORD_MAX, 1'b0, 0, '0));
      directed_rows.push_back(csr_row(nca_pkg::CSR_ACTIVE_CLUSTERS, 31));
      directed_rows.push_back(beat_row(nca_pkg::OP_CLASSIFY, 0, COORD_MAX, COORD_MAX,
                                       COORD_MAX, COORD_MAX, 1'b1, 15, '0));
      directed_rows.push_back(beat_row(nca_pkg::OP_CLASSIFY, 0, COORD_MIN, COORD_MIN,
                                       COORD_MIN, COORD_MIN, 1'b1, 0, '0));
      directed_rows.push_back(csr_row(nca_pkg::CSR_ACTIVE_CLUSTERS, 0));
      directed_rows.push_back(beat_row(nca_pkg::OP_CLASSIFY, 7, COORD_MAX, COORD_MAX,
                                       COORD_MAX, COORD_MAX, 1'b1, 0, CORNER_DISTANCE));
      directed_rows.push_back(csr_row(nca_pkg::CSR_ACTIVE_CLUSTERS, 16));
      directed_rows.push_back(csr_row(nca_pkg::CSR_ACTIVE_DIMS, 0));
      directed_rows.push_back(beat_row(nca_pkg::OP_CLASSIFY, 3, 1234, -4321, COORD_MAX,
                                       COORD_MIN, 1'b1, 0, '0));
      directed_rows.push_back(csr_row(nca_pkg::CSR_ACTIVE_DIMS, 7));
      directed_rows.push_back(beat_row(nca_pkg::OP_CLASSIFY, 0, 0, 0, 0, 0, 1'b0, 0, '0));
      directed_rows.push_back(beat_row(nca_pkg::OP_CLASSIFY, 0, -12000, 9000, 111, -77,
                                       1'b1, 2, '0));
      directed_rows.push_back(csr_row(nca_pkg::CSR_ACTIVE_DIMS, 1));
      directed_rows.push_back(csr_row(nca_pkg::CSR_ACTIVE_CLUSTERS, 2));
      directed_rows.push_back(beat_row(nca_pkg::OP_CLASSIFY, 0, COORD_MIN, COORD_MAX,
                                       COORD_MAX, COORD_MAX, 1'b1, 0, '0));

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         if (directed_rows[k].kind == ROW_CSR) begin
            settle();
            csr_write(directed_rows[k].reg_index, directed_rows[k].reg_value);
         end else begin
            send_beat(directed_rows[k].beat, directed_rows[k].typed, directed_rows[k].answer);
         end
      end

      for (p = 0; p < PHASE_COUNT; p++) begin
         settle();
         csr_write(nca_pkg::CSR_ACTIVE_CLUSTERS, nca_pkg::CSR_DATA_WIDTH'(phase_clusters[p]));
         csr_write(nca_pkg::CSR_ACTIVE_DIMS, nca_pkg::CSR_DATA_WIDTH'(phase_dims[p]));
         sender_idle_pct = (p % 4 == 1) ? 64 : (p % 4 == 3) ? 19 : 0;
         receiver_stall_pct = (p % 4 == 2) ? 64 : (p % 4 == 3) ? 19 : 0;
         repeat (PHASE_ITEMS) begin
            beat.entry_index = nca_pkg::ENTRY_WIDTH'($urandom_range(CLUSTER_SLOTS - 1));
            beat.coord_zero = pick_coord();
            beat.coord_one = pick_coord();
            beat.coord_two = pick_coord();
            beat.coord_three = pick_coord();
            pick = $urandom_range(CLUSTER_SLOTS - 1);
            if ($urandom_range(99) < 30) begin
               beat.op = nca_pkg::OP_LOAD;
               if ($urandom_range(9) == 0) begin
                  beat.coord_zero = centroid_mirror[pick][0];
                  beat.coord_one = centroid_mirror[pick][1];
                  beat.coord_two = centroid_mirror[pick][2];
                  beat.coord_three = centroid_mirror[pick][3];
               end
            end else begin
               beat.op = nca_pkg::OP_CLASSIFY;
               if ($urandom_range(1) == 0) begin
                  beat.coord_zero = near_coord(centroid_mirror[pick][0]);
                  beat.coord_one = near_coord(centroid_mirror[pick][1]);
                  beat.coord_two = near_coord(centroid_mirror[pick][2]);
                  beat.coord_three = near_coord(centroid_mirror[pick][3]);
               end
            end
            send_beat(beat, 1'b0, '0);
         end
      end

      settle();
      if (error_count == 0) begin
         $display("nearest_centroid_assign_unit_test: done, clean");
      end else begin
         $display("nearest_centroid_assign_unit_test: done, errors");
      end
      $finish;
   end

endmodule
